FILE: rtl/core/linear_probe_hash_map_defines.svh
// Assertion macros shared by the hash map RTL.
`ifndef LINEAR_PROBE_HASH_MAP_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define LPHM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define LPHM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lphm_pkg.sv
// Types and constants of the linear probing hash map.
package lphm_pkg;

  // Table geometry.
  localparam int TABLE_SLOTS = 1023;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;

  // Home slot by reciprocal multiplication: q = (key * RECIP) >> RECIP_SHIFT
  // is the true quotient or one less, so the remainder needs one correction.
  localparam int RECIP_SHIFT = KEY_W + SLOT_W;
  localparam int RECIP_W     = KEY_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(TABLE_SLOTS));
  localparam int PROD_W      = KEY_W + RECIP_W;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;
  localparam int REM_W       = SLOT_W + 1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } lphm_op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_ZERO_KEY  = 2'd3
  } lphm_status_t;

  typedef struct packed {
    lphm_op_t             operation;
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value_in;
  } lphm_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   value_out;
    lphm_status_t         status;
  } lphm_out_t;

  // One table entry; a key of zero marks the slot as empty.
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [VALUE_W-1:0]   value;
  } lphm_entry_t;

endpackage

FILE: rtl/core/linear_probe_hash_map.sv
// Top level of the linear probing hash map: sequencer, home slot unit and table.
//
//   channel  | ports                          | transaction
//   ---------+--------------------------------+-------------------------------
//   input    | in_valid, in_stall, in_data    | insert or lookup request
//   output   | out_valid, out_stall, out_data | value and status, one per item
//
// An item passes from acceptance through the multiply, fold and home states and then
// probes one or more slots; the table RAM delivers one slot a cycle.
// Inserts into a full table and zero keys skip the probe and go straight to the response state.
// After reset a clearing pass writes all TABLE_SLOTS entries, one a cycle, and
// no item is accepted until it ends.
// A result waits in the output register while out_stall is high; the next one
// waits in the response state until that register is free.
`include "linear_probe_hash_map_defines.svh"

module linear_probe_hash_map
  import lphm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lphm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output lphm_out_t out_data
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH_MUL,
    ST_HASH_FOLD,
    ST_HASH_HOME,
    ST_PROBE,
    ST_RESP
  } state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  state_t              state_r, state_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOT_W-1:0]   probe_cnt_r, probe_cnt_nxt;
  logic [CNT_W-1:0]    used_cnt_r, used_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  lphm_out_t           out_data_r, out_data_nxt;
  lphm_out_t           res_r, res_nxt;
  lphm_op_t            op_r, op_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [VALUE_W-1:0]  value_r, value_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [REM_W-1:0]    qd_r, qd_nxt;

  logic                ram_we;
  lphm_entry_t         ram_wdata;
  lphm_entry_t         ram_rdata;
  logic [Q_W-1:0]      quot;
  logic [REM_W-1:0]    rem_raw;
  logic [REM_W-1:0]    rem_fix;
  logic [SLOT_W-1:0]   home_slot;
  logic [SLOT_W-1:0]   step_slot;
  logic                probe_last;

  // Table of keys and values; the read address follows the next slot so that
  // the entry of the current slot is ready in the cycle after it is chosen.
  lphm_ram #(
    .WIDTH ($bits(lphm_entry_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .raddr (slot_nxt),
    .rdata (ram_rdata)
  );

  // Home slot: remainder from the estimated quotient, then one correction.
  assign quot      = prod_r[PROD_W-1:RECIP_SHIFT];
  assign rem_raw   = key_r[REM_W-1:0] - qd_r;
  assign rem_fix   = (rem_raw >= REM_W'(TABLE_SLOTS)) ? rem_raw - REM_W'(TABLE_SLOTS)
                                                      : rem_raw;
  assign home_slot = rem_fix[SLOT_W-1:0];

  // Next slot on the probe chain wraps from the last slot to slot zero.
  assign step_slot  = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
  assign probe_last = (probe_cnt_r == LAST_SLOT);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer next-state and datapath logic.
  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    probe_cnt_nxt = probe_cnt_r;
    used_cnt_nxt  = used_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    res_nxt       = res_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    prod_nxt      = prod_r;
    qd_nxt        = qd_r;
    ram_we        = 1'b0;
    ram_wdata     = '0;

    // The consumer takes the waiting result.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (slot_r == LAST_SLOT) begin
          slot_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.operation;
          key_nxt   = in_data.key;
          value_nxt = in_data.value_in;
          if (in_data.key == '0) begin
            res_nxt   = '{value_out: '0, status: STATUS_ZERO_KEY};
            state_nxt = ST_RESP;
          end else if (in_data.operation == OP_INSERT &&
                       used_cnt_r == CNT_W'(TABLE_SLOTS)) begin
            res_nxt   = '{value_out: '0, status: STATUS_FULL};
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_HASH_MUL;
          end
        end
      end

      ST_HASH_MUL: begin
        prod_nxt  = PROD_W'(key_r) * PROD_W'(RECIP);
        state_nxt = ST_HASH_FOLD;
      end

      ST_HASH_FOLD: begin
        qd_nxt    = REM_W'(quot * Q_W'(TABLE_SLOTS));
        state_nxt = ST_HASH_HOME;
      end

      ST_HASH_HOME: begin
        slot_nxt      = home_slot;
        probe_cnt_nxt = '0;
        state_nxt     = ST_PROBE;
      end

      ST_PROBE: begin
        if (op_r == OP_LOOKUP) begin
          if (ram_rdata.key == key_r) begin
            res_nxt   = '{value_out: ram_rdata.value, status: STATUS_OK};
            state_nxt = ST_RESP;
          end else if (ram_rdata.key == '0 || probe_last) begin
            res_nxt   = '{value_out: '0, status: STATUS_NOT_FOUND};
            state_nxt = ST_RESP;
          end else begin
            slot_nxt      = step_slot;
            probe_cnt_nxt = probe_cnt_r + SLOT_W'(1);
          end
        end else begin
          if (ram_rdata.key == '0) begin
            ram_we       = 1'b1;
            ram_wdata    = '{key: key_r, value: value_r};
            used_cnt_nxt = used_cnt_r + CNT_W'(1);
            res_nxt      = '{value_out: '0, status: STATUS_OK};
            state_nxt    = ST_RESP;
          end else if (probe_last) begin
            res_nxt   = '{value_out: '0, status: STATUS_FULL};
            state_nxt = ST_RESP;
          end else begin
            slot_nxt      = step_slot;
            probe_cnt_nxt = probe_cnt_r + SLOT_W'(1);
          end
        end
      end

      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, counters, registered outputs and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      slot_r      <= '0;
      used_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      used_cnt_r  <= used_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    probe_cnt_r <= probe_cnt_nxt;
    out_data_r  <= out_data_nxt;
    res_r       <= res_nxt;
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    value_r     <= value_nxt;
    prod_r      <= prod_nxt;
    qd_r        <= qd_nxt;
  end

  // The occupancy count stays within the table.
  `LPHM_ASSERT_NOW(a_used_in_range, 1'b1, used_cnt_r <= CNT_W'(TABLE_SLOTS), "used count above table size")
  // The table is written only by the clearing pass or by an insert.
  `LPHM_ASSERT_NOW(a_write_source, ram_we, state_r == ST_CLEAR || (state_r == ST_PROBE && op_r == OP_INSERT), "table write outside clear or insert")
  // An insert that fills a slot raises the occupancy count by one.
  `LPHM_ASSERT_NEXT(a_insert_counts, state_r == ST_PROBE && ram_we, used_cnt_r == $past(used_cnt_r) + CNT_W'(1), "insert did not count")
  // The probed slot always lies inside the table.
  `LPHM_ASSERT_NOW(a_slot_in_range, state_r == ST_PROBE, slot_r <= LAST_SLOT, "probe slot outside table")
  // An accepted transaction either starts hashing or answers at once.
  `LPHM_ASSERT_NEXT(a_accept_path, in_valid && !in_stall, state_r == ST_HASH_MUL || state_r == ST_RESP, "bad state after accept")

endmodule

FILE: rtl/core/lphm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lphm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
